// ===== rtl/ibf_pkg.sv =====
// shared types and constants of the ipv4 blocklist filter
`default_nettype none

package ibf_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    // request codes
    localparam logic [1:0] REQ_CHECK   = 2'd0;
    localparam logic [1:0] REQ_BLOCK   = 2'd1;
    localparam logic [1:0] REQ_UNBLOCK = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SH_RD,
        S_SH_WR,
        S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_next;
        logic set_found;
        logic idx_inc;
        logic shift_wr;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       idx_lt_used;
        logic       match;
        logic       more_shift;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/ibf_ctrl.sv =====
// controller state machine: table scan, gap closing and result sequencing
`default_nettype none

module ibf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire ibf_pkg::t_stat i_stat,
    output ibf_pkg::t_cmd      o_cmd,
    output logic               o_busy
);

    ibf_pkg::t_state r_state;
    ibf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ibf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ibf_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ibf_pkg::S_READ;
                end
            end
            ibf_pkg::S_READ: begin
                if (i_stat.req != ibf_pkg::REQ_CHECK && i_stat.req != ibf_pkg::REQ_BLOCK &&
                    i_stat.req != ibf_pkg::REQ_UNBLOCK) begin
                    n_state = ibf_pkg::S_FIN;
                end else if (i_stat.idx_lt_used) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ibf_pkg::S_CMP;
                end else begin
                    n_state = ibf_pkg::S_FIN;
                end
            end
            ibf_pkg::S_CMP: begin
                if (i_stat.match) begin
                    o_cmd.set_found = 1'b1;
                    if (i_stat.req == ibf_pkg::REQ_UNBLOCK) begin
                        n_state = ibf_pkg::S_SH_RD;
                    end else begin
                        n_state = ibf_pkg::S_FIN;
                    end
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = ibf_pkg::S_READ;
                end
            end
            ibf_pkg::S_SH_RD: begin
                // pull the next entry down one slot until the end of the table
                if (i_stat.more_shift) begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_next = 1'b1;
                    n_state       = ibf_pkg::S_SH_WR;
                end else begin
                    n_state = ibf_pkg::S_FIN;
                end
            end
            ibf_pkg::S_SH_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = ibf_pkg::S_SH_RD;
            end
            ibf_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ibf_pkg::S_IDLE;
            end
            default: begin
                n_state = ibf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ibf_pkg::S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/ibf_dp.sv =====
// datapath: address table memory, entry count, packet counters and result registers
`default_nettype none

module ibf_dp #(
    parameter int TABLE_DEPTH = ibf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_wdata,
    input  wire logic [1:0]     i_req_type,
    input  wire logic [31:0]    i_ip_addr,
    input  wire ibf_pkg::t_cmd  i_cmd,
    output ibf_pkg::t_stat      o_stat,
    output logic                o_valid,
    output logic                o_drop,
    output logic [1:0]          o_status,
    output logic [7:0]          o_entry_count,
    output logic [47:0]         o_seen_total,
    output logic [47:0]         o_dropped_total
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [31:0]   r_mem [TABLE_DEPTH];
    logic [31:0]   r_rd_data;

    logic          r_filter_en;
    logic [1:0]    r_req;
    logic [31:0]   r_addr;
    logic [CW-1:0] r_idx;
    logic          r_found;
    logic [CW-1:0] r_used;
    logic [47:0]   r_seen;
    logic [47:0]   r_dropped;

    logic          r_valid;
    logic          r_drop;
    logic [1:0]    r_status;

    logic [CW-1:0] idx_plus1;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [CW-1:0] n_used;
    logic [47:0]   n_seen;
    logic [47:0]   n_dropped;
    logic          n_drop;
    logic [1:0]    n_status;
    logic          app_we;

    assign idx_plus1 = r_idx + CW'(1);
    assign rd_addr   = i_cmd.rd_next ? idx_plus1[AW-1:0] : r_idx[AW-1:0];
    assign wr_en     = i_cmd.shift_wr | (i_cmd.finish & app_we);
    assign wr_addr   = i_cmd.shift_wr ? r_idx[AW-1:0] : r_used[AW-1:0];
    assign wr_data   = i_cmd.shift_wr ? r_rd_data : r_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // outcome of the request once the scan is over
    always_comb begin
        n_used    = r_used;
        n_seen    = r_seen;
        n_dropped = r_dropped;
        n_drop    = 1'b0;
        n_status  = ibf_pkg::ST_OK;
        app_we    = 1'b0;
        case (r_req)
            ibf_pkg::REQ_CHECK: begin
                n_seen = r_seen + 48'd1;
                if (r_filter_en && r_found) begin
                    n_dropped = r_dropped + 48'd1;
                    n_drop    = 1'b1;
                end
            end
            ibf_pkg::REQ_BLOCK: begin
                if (!r_found) begin
                    if (r_used >= CW'(TABLE_DEPTH)) begin
                        n_status = ibf_pkg::ST_FULL;
                    end else begin
                        app_we = 1'b1;
                        n_used = r_used + CW'(1);
                    end
                end
            end
            ibf_pkg::REQ_UNBLOCK: begin
                if (!r_found) begin
                    n_status = ibf_pkg::ST_NOT_FOUND;
                end else begin
                    n_used = r_used - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= 1'b1;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_used      <= '0;
            r_seen      <= '0;
            r_dropped   <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_filter_en <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_plus1;
            end
            if (i_cmd.set_found) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_used    <= n_used;
                r_seen    <= n_seen;
                r_dropped <= n_dropped;
            end
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_addr <= i_ip_addr;
        end
        if (i_cmd.finish) begin
            r_drop   <= n_drop;
            r_status <= n_status;
        end
    end

    assign o_stat.req         = r_req;
    assign o_stat.idx_lt_used = (r_idx < r_used);
    assign o_stat.match       = (r_rd_data == r_addr);
    assign o_stat.more_shift  = (idx_plus1 < r_used);

    assign o_valid         = r_valid;
    assign o_drop          = r_drop;
    assign o_status        = r_status;
    assign o_entry_count   = 8'(r_used);
    assign o_seen_total    = r_seen;
    assign o_dropped_total = r_dropped;

endmodule

`default_nettype wire

// ===== rtl/ipv4_blocklist_filter.sv =====
// top level of the ipv4 blocklist filter: controller, datapath and checks
//
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+---------------------------------------------
// request   | in        | start & !busy       | i_req_type, i_ip_addr
// result    | out       | o_valid, one cycle  | o_drop, o_status, o_entry_count, o_*_total
// config    | in        | i_cfg_we            | i_cfg_wdata (filter enable)
//
// one request at a time; busy stays high from acceptance until the result strobe
// each entry is read and compared in order until a match or the end of the table; on
// an unblock that finds its entry, every later entry is then read and moved down one slot
// the single read port of the table memory sets the pace
// synchronous active low reset; the table memory itself is not cleared
// results cannot be stalled; o_valid pulses for one cycle per request
`default_nettype none

module ipv4_blocklist_filter #(
    parameter int TABLE_DEPTH = ibf_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_ip_addr,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    output logic             o_valid,
    output logic             o_drop,
    output logic [1:0]       o_status,
    output logic [7:0]       o_entry_count,
    output logic [47:0]      o_seen_total,
    output logic [47:0]      o_dropped_total
);

    ibf_pkg::t_cmd  cmd;
    ibf_pkg::t_stat stat;
    logic           ctrl_busy;

    ibf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    ibf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req_type      (i_req_type),
        .i_ip_addr       (i_ip_addr),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_drop          (o_drop),
        .o_status        (o_status),
        .o_entry_count   (o_entry_count),
        .o_seen_total    (o_seen_total),
        .o_dropped_total (o_dropped_total)
    );

    assign busy = ctrl_busy;

`ifndef SYNTHESIS
    // a result only follows a cycle in which a request was in progress
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a request in progress");

    // an accepted request keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // a full error only happens with the table at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ibf_pkg::ST_FULL) |-> (o_entry_count == 8'(TABLE_DEPTH)))
        else $error("table full reported with spare entries");

    // a drop verdict never comes with an error status
    a_drop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drop) |-> (o_status == ibf_pkg::ST_OK))
        else $error("drop verdict with error status");
`endif

endmodule

`default_nettype wire

// ===== verif/ipv4_blocklist_filter_tb.sv =====
// testbench for the ipv4 blocklist filter: directed and random requests, scoreboard check
`timescale 1ns / 1ps

module ipv4_blocklist_filter_tb;

    localparam int DEPTH = ibf_pkg::TABLE_DEPTH_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int POOL_SIZE = 24;

    typedef struct packed {
        logic        drop;
        logic [1:0]  status;
        logic [7:0]  entry_count;
        logic [47:0] seen;
        logic [47:0] dropped;
    } t_filter_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_req_type;
    logic [31:0] i_ip_addr;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        o_valid;
    logic        o_drop;
    logic [1:0]  o_status;
    logic [7:0]  o_entry_count;
    logic [47:0] o_seen_total;
    logic [47:0] o_dropped_total;

    // shadow of the block state, updated when a request is accepted
    logic [31:0]    blocked_addrs[$];
    logic           filter_en;
    logic [47:0]    seen_count;
    logic [47:0]    dropped_count;
    t_filter_result pending_results[$];
    logic [31:0]    addr_pool[POOL_SIZE];

    int mismatch_count;
    int quiet_cycles;
    bit idle_on;

    ipv4_blocklist_filter #(
        .TABLE_DEPTH(DEPTH)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_ip_addr      (i_ip_addr),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_valid        (o_valid),
        .o_drop         (o_drop),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_seen_total   (o_seen_total),
        .o_dropped_total(o_dropped_total)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int find_blocked(input logic [31:0] addr);
        for (int i = 0; i < blocked_addrs.size(); i++) begin
            if (blocked_addrs[i] == addr) return i;
        end
        return -1;
    endfunction

    function automatic t_filter_result apply_request(input logic [1:0] req,
                                                     input logic [31:0] addr);
        t_filter_result res;
        int pos;
        res = '0;
        pos = find_blocked(addr);
        case (req)
            ibf_pkg::REQ_CHECK: begin
                seen_count = seen_count + 48'd1;
                if (filter_en && pos >= 0) begin
                    dropped_count = dropped_count + 48'd1;
                    res.drop = 1'b1;
                end
            end
            ibf_pkg::REQ_BLOCK: begin
                if (pos < 0) begin
                    if (blocked_addrs.size() >= DEPTH) res.status = ibf_pkg::ST_FULL;
                    else blocked_addrs.push_back(addr);
                end
            end
            ibf_pkg::REQ_UNBLOCK: begin
                // later entries move down, order kept
                if (pos < 0) res.status = ibf_pkg::ST_NOT_FOUND;
                else blocked_addrs.delete(pos);
            end
            default: ;
        endcase
        res.entry_count = 8'(blocked_addrs.size());
        res.seen = seen_count;
        res.dropped = dropped_count;
        return res;
    endfunction

    task automatic send_request(input logic [1:0] req, input logic [31:0] addr);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 9);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_req_type = req;
        i_ip_addr = addr;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_request(req, addr));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_filter_enable(input logic en);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_wdata = en;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        filter_en = en;
    endtask

    task automatic report_field(input string field, input logic [47:0] exp_val,
                                input logic [47:0] act_val);
        if (exp_val !== act_val) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch %s: expected %0h actual %0h at %0t",
                         field, exp_val, act_val, $realtime);
        end
    endtask

    t_filter_result exp_res;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("mismatch: result with no request pending at %0t", $realtime);
            end else begin
                exp_res = pending_results.pop_front();
                report_field("drop", 48'(exp_res.drop), 48'(o_drop));
                report_field("status", 48'(exp_res.status), 48'(o_status));
                report_field("entry_count", 48'(exp_res.entry_count), 48'(o_entry_count));
                report_field("seen_total", exp_res.seen, o_seen_total);
                report_field("dropped_total", exp_res.dropped, o_dropped_total);
            end
        end
    end

    // watchdog on cycles with no request accepted and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_directed_requests();
        write_filter_enable(1'b1);
        send_request(ibf_pkg::REQ_CHECK, 32'h0000_0000);
        send_request(ibf_pkg::REQ_UNBLOCK, 32'h0000_0000);
        send_request(ibf_pkg::REQ_BLOCK, 32'h0000_0000);
        send_request(ibf_pkg::REQ_BLOCK, 32'hFFFF_FFFF);
        send_request(ibf_pkg::REQ_BLOCK, 32'hFFFF_FFFF);
        send_request(ibf_pkg::REQ_CHECK, 32'hFFFF_FFFF);
        send_request(ibf_pkg::REQ_CHECK, 32'h0000_0000);
        send_request(ibf_pkg::REQ_CHECK, 32'hFFFF_FFFE);
        send_request(ibf_pkg::REQ_UNBLOCK, 32'h1234_5678);
        send_request(REQ_UNUSED, 32'hFFFF_FFFF);
        send_request(REQ_UNUSED, 32'h0000_0000);
        send_request(ibf_pkg::REQ_UNBLOCK, 32'h0000_0000);
        send_request(ibf_pkg::REQ_CHECK, 32'h0000_0000);
        send_request(ibf_pkg::REQ_CHECK, 32'hFFFF_FFFF);
    endtask

    task automatic test_filter_disabled();
        write_filter_enable(1'b0);
        send_request(ibf_pkg::REQ_CHECK, 32'hFFFF_FFFF);
        send_request(ibf_pkg::REQ_BLOCK, 32'h8000_0000);
        send_request(ibf_pkg::REQ_CHECK, 32'h8000_0000);
        send_request(ibf_pkg::REQ_UNBLOCK, 32'h8000_0000);
        write_filter_enable(1'b1);
        send_request(ibf_pkg::REQ_CHECK, 32'hFFFF_FFFF);
    endtask

    task automatic test_table_full();
        logic [31:0] newest;
        while (blocked_addrs.size() < DEPTH) send_request(ibf_pkg::REQ_BLOCK, $urandom());
        send_request(ibf_pkg::REQ_BLOCK, $urandom());
        send_request(ibf_pkg::REQ_BLOCK, blocked_addrs[5]);
        send_request(ibf_pkg::REQ_CHECK, blocked_addrs[DEPTH - 1]);
        send_request(ibf_pkg::REQ_CHECK, blocked_addrs[0]);
        send_request(ibf_pkg::REQ_UNBLOCK, blocked_addrs[DEPTH / 2]);
        send_request(ibf_pkg::REQ_UNBLOCK, blocked_addrs[0]);
        send_request(ibf_pkg::REQ_UNBLOCK, blocked_addrs[blocked_addrs.size() - 1]);
        repeat (4) send_request(ibf_pkg::REQ_BLOCK, $urandom());
        newest = blocked_addrs[blocked_addrs.size() - 1];
        send_request(ibf_pkg::REQ_CHECK, newest);
        // empty the table again in random order
        while (blocked_addrs.size() > 0) begin
            if ($urandom_range(0, 4) == 0)
                send_request(ibf_pkg::REQ_CHECK,
                             blocked_addrs[$urandom_range(0, blocked_addrs.size() - 1)]);
            send_request(ibf_pkg::REQ_UNBLOCK,
                         blocked_addrs[$urandom_range(0, blocked_addrs.size() - 1)]);
        end
        send_request(ibf_pkg::REQ_CHECK, newest);
    endtask

    task automatic run_mixed_traffic(input int n_items, input bit allow_idle);
        int pick;
        logic [1:0] req;
        logic [31:0] addr;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 0) idle_on = allow_idle && ($urandom_range(0, 2) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 50) req = ibf_pkg::REQ_CHECK;
            else if (pick < 75) req = ibf_pkg::REQ_BLOCK;
            else if (pick < 95) req = ibf_pkg::REQ_UNBLOCK;
            else req = REQ_UNUSED;
            // mostly pool addresses so lookups hit; strays kept rare on blocks
            if (req == ibf_pkg::REQ_BLOCK) pick = $urandom_range(0, 19);
            else pick = $urandom_range(0, 3);
            if (pick != 0) addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
            else addr = $urandom();
            send_request(req, addr);
        end
    endtask

    task automatic test_random_traffic();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        addr_pool[2] = 32'h8000_0000;
        addr_pool[3] = 32'h0000_0001;
        for (int i = 4; i < POOL_SIZE; i++) begin
            // some entries differ from another by a single bit
            if (i % 4 == 0) addr_pool[i] = addr_pool[i - 3] ^ (32'd1 << $urandom_range(0, 31));
            else addr_pool[i] = $urandom();
        end
        write_filter_enable(1'b1);
        run_mixed_traffic(350, 1'b1);
        write_filter_enable(1'b0);
        run_mixed_traffic(200, 1'b1);
        write_filter_enable(1'b1);
        run_mixed_traffic(100, 1'b1);
        idle_on = 1'b0;
        run_mixed_traffic(320, 1'b0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = ibf_pkg::REQ_CHECK;
        i_ip_addr = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        filter_en = 1'b1;
        seen_count = '0;
        dropped_count = '0;
        mismatch_count = 0;
        idle_on = 1'b1;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_requests();
        test_filter_disabled();
        test_table_full();
        test_random_traffic();

        wait_drained();
        repeat (10) @(posedge i_clk);
        mismatch_count += pending_results.size();
        if (mismatch_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
